### sv/assert_macros.svh
// assertion helper macros for the wildcard key matcher
// used by the top level rtl file in this folder; expand to nothing when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define WKCM_ASSERT_ALWAYS(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define WKCM_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define WKCM_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define WKCM_ASSERT_ALWAYS(name, clk, rst, expr, msg)

`define WKCM_ASSERT_IMPLY(name, clk, rst, ante, cons, msg)

`define WKCM_ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

### sv/wkcm_pkg.sv
`timescale 1ns / 1ps
// shared constants and types of the wildcard key matcher
// no dependencies; imported by wkcm_key_match and the top level
package wkcm_pkg;

   localparam int SYMBOL_BITS = 6;
   localparam int KEY_SYMBOLS = 5;
   localparam int MAX_CHOICES = 10;
   localparam int CHAR_BITS   = 16;

   localparam int KEY_BITS    = SYMBOL_BITS * KEY_SYMBOLS;
   localparam int POS_BITS    = $clog2(KEY_SYMBOLS + 1);
   localparam int COUNT_BITS  = $clog2(MAX_CHOICES + 1);
   localparam int LENGTH_BITS = 3;
   localparam int OFFSET_BITS = 16;
   localparam int SLOT_BITS   = 4;
   localparam int LABEL_MOD   = 10;

   localparam int REQ_DATA_BITS = ((KEY_BITS + CHAR_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((2 * SLOT_BITS + CHAR_BITS + 7) / 8) * 8;
   localparam int RSP_USER_BITS = 4;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [SYMBOL_BITS-1:0] sym_type;
   typedef logic [POS_BITS-1:0]    pos_type;

   localparam sym_type ANY_ONE = sym_type'(61);
   localparam sym_type ANY_RUN = sym_type'(62);

   typedef struct packed {
      logic [KEY_BITS-1:0]    symbols;
      logic [LENGTH_BITS-1:0] sym_count;
   } pattern_cfg_type;

   typedef enum logic [1:0] {
      REG_PATTERN_SYMBOLS = 2'd0,
      REG_PATTERN_LENGTH  = 2'd1,
      REG_PAGE_OFFSET     = 2'd2
   } reg_index_type;

endpackage

### sv/wkcm_key_match.sv
`timescale 1ns / 1ps
// wildcard pattern walk over one packed key, purely combinational
// depends on wkcm_pkg for widths, wildcard codes and the pattern struct
module wkcm_key_match (
   input  logic [wkcm_pkg::KEY_BITS-1:0] key,
   input  wkcm_pkg::pattern_cfg_type     pattern,
   output logic                          is_match
);
   import wkcm_pkg::*;

   sym_type key_sym [KEY_SYMBOLS+1];
   sym_type pat_sym [KEY_SYMBOLS+1];
   logic    rem_nz  [KEY_SYMBOLS+1];

   // split key and pattern, top symbol first; extra slot reads as an empty key
   always_comb begin
      for (int q = 0; q < KEY_SYMBOLS; q++) begin
         key_sym[q] = key[KEY_BITS-1-q*SYMBOL_BITS -: SYMBOL_BITS];
         pat_sym[q] = pattern.symbols[KEY_BITS-1-q*SYMBOL_BITS -: SYMBOL_BITS];
      end
      key_sym[KEY_SYMBOLS] = '0;
      pat_sym[KEY_SYMBOLS] = '0;
      rem_nz[KEY_SYMBOLS]  = 1'b0;
      for (int q = KEY_SYMBOLS - 1; q >= 0; q--) begin
         rem_nz[q] = rem_nz[q+1] | (key_sym[q] != '0);
      end
   end

   // one unrolled step per pattern position; each step that matches advances the pattern
   always_comb begin
      pos_type n;
      pos_type pat_idx;
      pos_type key_pos;
      pos_type p;
      pos_type z;
      logic    ok;
      sym_type s;
      sym_type nxt;

      n = (pattern.sym_count > KEY_SYMBOLS) ? POS_BITS'(KEY_SYMBOLS)
                                             : POS_BITS'(pattern.sym_count);
      pat_idx = '0;
      key_pos = '0;
      ok      = 1'b1;
      s       = '0;
      nxt     = '0;
      p       = '0;
      z       = '0;

      for (int k = 0; k < KEY_SYMBOLS; k++) begin
         if (pat_idx < n && ok && rem_nz[key_pos]) begin
            s = pat_sym[pat_idx];
            if (s == ANY_ONE) begin
               key_pos = POS_BITS'(key_pos + 1);
               pat_idx = POS_BITS'(pat_idx + 1);
            end else if (s == ANY_RUN) begin
               if (POS_BITS'(pat_idx + 1) == n) begin
                  // trailing run eats the rest
                  key_pos = POS_BITS'(KEY_SYMBOLS);
                  pat_idx = n;
               end else begin
                  nxt = pat_sym[POS_BITS'(pat_idx + 1)];
                  if (nxt == ANY_ONE || nxt == ANY_RUN) begin
                     pat_idx = POS_BITS'(pat_idx + 2);
                  end else if (POS_BITS'(pat_idx + 2) == n) begin
                     // run then final symbol: the last nonzero symbol must be nxt
                     // with no zero symbol before it
                     z = POS_BITS'(KEY_SYMBOLS);
                     for (int q = KEY_SYMBOLS - 1; q >= 0; q--) begin
                        if (q >= int'(key_pos) && key_sym[q] == '0) begin
                           z = POS_BITS'(q);
                        end
                     end
                     ok = (nxt == '0) ||
                          (z != key_pos && !rem_nz[z] &&
                           key_sym[POS_BITS'(z - 1)] == nxt);
                     key_pos = POS_BITS'(KEY_SYMBOLS);
                     pat_idx = n;
                  end else begin
                     // drop up to and including the first nxt or zero symbol
                     p = POS_BITS'(KEY_SYMBOLS);
                     for (int q = KEY_SYMBOLS - 1; q >= 0; q--) begin
                        if (q >= int'(key_pos) && (key_sym[q] == nxt || key_sym[q] == '0)) begin
                           p = POS_BITS'(q);
                        end
                     end
                     ok = (key_sym[p] == nxt);
                     key_pos = (p == POS_BITS'(KEY_SYMBOLS)) ? p : POS_BITS'(p + 1);
                     pat_idx = POS_BITS'(pat_idx + 2);
                  end
               end
            end else begin
               ok = (s == key_sym[key_pos]);
               if (ok) begin
                  key_pos = POS_BITS'(key_pos + 1);
                  pat_idx = POS_BITS'(pat_idx + 1);
               end
            end
         end
      end

      is_match = (pat_idx == n) && ok && !rem_nz[key_pos];
   end

endmodule

### sv/wildcard_key_code_matcher.sv
`timescale 1ns / 1ps
// top level of the wildcard key matcher: stream ports, csr block, scan counters
// depends on wkcm_pkg, wkcm_key_match and assert_macros.svh
//
//   channel   ports   direction   payload
//   -------   -----   ---------   -----------------------------------------------
//   request   req_*   in          entry_key, entry_char, first_entry, last_entry
//   result    rsp_*   out         match flags, choice slot, label and char
//   config    csr_*   in/out      pattern_symbols, pattern_length, page_offset
//
// one request per cycle sustained while rsp_tready is high; each taken request goes through
// the input register, then the result register, and the match walk sits between them
// a stalled result register holds; the input register still takes one more request
// synchronous active-high reset clears the valid bits, the scan counters, the pattern
// symbols and the page offset, and sets the pattern length to one
`include "assert_macros.svh"

module wildcard_key_code_matcher (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // entry_key [29:0], entry_char [45:30], zero pad
   input  logic [wkcm_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // first_entry
   input  logic                                  req_tuser,
   // last_entry
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // choice_slot [3:0], choice_label [7:4], choice_char [23:8]
   output logic [wkcm_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // matched [0], taken [1], list_full [2], none_found [3]
   output logic [wkcm_pkg::RSP_USER_BITS-1:0]    rsp_tuser,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [wkcm_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [wkcm_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [wkcm_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready
);
   import wkcm_pkg::*;

   // configuration
   logic [KEY_BITS-1:0]    pattern_symbols_ff;
   logic [LENGTH_BITS-1:0] pattern_length_ff;
   logic [OFFSET_BITS-1:0] page_offset_ff;
   logic                   csr_write;
   pattern_cfg_type        pattern_cfg;

   // input register
   logic                   a_valid_ff, a_valid_in;
   logic [KEY_BITS-1:0]    a_key_ff;
   logic [CHAR_BITS-1:0]   a_char_ff;
   logic                   a_first_ff;
   logic                   a_last_ff;
   logic                   req_accept;
   logic                   advance;

   // scan counters
   logic [COUNT_BITS-1:0]  choices_taken_ff, choices_taken_in;
   logic [OFFSET_BITS-1:0] matches_skipped_ff, matches_skipped_in;
   logic                   any_found_ff, any_found_in;
   logic [COUNT_BITS-1:0]  ct_cur;
   logic [OFFSET_BITS-1:0] ms_cur;
   logic                   any_cur;
   logic                   key_hit;
   logic                   hit;
   logic                   take;
   logic [SLOT_BITS-1:0]   label_sum;

   // result register
   logic                   b_valid_ff, b_valid_in;
   logic                   rsp_matched_ff, rsp_matched_in;
   logic                   rsp_taken_ff, rsp_taken_in;
   logic [SLOT_BITS-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [SLOT_BITS-1:0]   rsp_label_ff, rsp_label_in;
   logic [CHAR_BITS-1:0]   rsp_char_ff, rsp_char_in;
   logic                   rsp_full_ff, rsp_full_in;
   logic                   rsp_none_ff, rsp_none_in;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_symbols_ff <= '0;
         pattern_length_ff  <= LENGTH_BITS'(1);
         page_offset_ff     <= '0;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_PATTERN_SYMBOLS: pattern_symbols_ff <= csr_pwdata[KEY_BITS-1:0];
            REG_PATTERN_LENGTH:  pattern_length_ff  <= csr_pwdata[LENGTH_BITS-1:0];
            REG_PAGE_OFFSET:     page_offset_ff     <= csr_pwdata[OFFSET_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_PATTERN_SYMBOLS: csr_prdata = CSR_DATA_BITS'(pattern_symbols_ff);
         REG_PATTERN_LENGTH:  csr_prdata = CSR_DATA_BITS'(pattern_length_ff);
         REG_PAGE_OFFSET:     csr_prdata = CSR_DATA_BITS'(page_offset_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // flow control
   assign advance    = a_valid_ff & (~b_valid_ff | rsp_tready);
   assign req_tready = ~a_valid_ff | advance;
   assign req_accept = req_tvalid & req_tready;
   assign a_valid_in = req_accept | (a_valid_ff & ~advance);
   assign b_valid_in = advance | (b_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_key_ff   <= req_tdata[KEY_BITS-1:0];
         a_char_ff  <= req_tdata[KEY_BITS+CHAR_BITS-1:KEY_BITS];
         a_first_ff <= req_tuser;
         a_last_ff  <= req_tlast;
      end
   end

   // match walk
   assign pattern_cfg.symbols   = pattern_symbols_ff;
   assign pattern_cfg.sym_count = pattern_length_ff;

   wkcm_key_match u_match (
      .key      (a_key_ff),
      .pattern  (pattern_cfg),
      .is_match (key_hit)
   );

   // counter update and result fields
   always_comb begin
      ct_cur  = a_first_ff ? '0   : choices_taken_ff;
      ms_cur  = a_first_ff ? '0   : matches_skipped_ff;
      any_cur = a_first_ff ? 1'b0 : any_found_ff;

      hit  = (ct_cur < COUNT_BITS'(MAX_CHOICES)) && key_hit;
      take = hit && (ms_cur >= page_offset_ff);

      choices_taken_in   = take ? COUNT_BITS'(ct_cur + 1'b1) : ct_cur;
      // skipping stops once the offset is reached, so this cannot wrap
      matches_skipped_in = (hit && !take) ? OFFSET_BITS'(ms_cur + 1'b1) : ms_cur;
      any_found_in       = any_cur | hit;

      label_sum = SLOT_BITS'(SLOT_BITS'(ct_cur) + 1'b1);

      rsp_matched_in = hit;
      rsp_taken_in   = take;
      rsp_slot_in    = take ? SLOT_BITS'(ct_cur) : '0;
      rsp_label_in   = !take ? '0 :
                       (label_sum == SLOT_BITS'(LABEL_MOD)) ? '0 : label_sum;
      rsp_char_in    = take ? a_char_ff : '0;
      rsp_full_in    = (choices_taken_in >= COUNT_BITS'(MAX_CHOICES));
      rsp_none_in    = a_last_ff & ~any_found_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         choices_taken_ff   <= '0;
         matches_skipped_ff <= '0;
         any_found_ff       <= 1'b0;
      end else if (advance) begin
         choices_taken_ff   <= choices_taken_in;
         matches_skipped_ff <= matches_skipped_in;
         any_found_ff       <= any_found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_matched_ff <= rsp_matched_in;
         rsp_taken_ff   <= rsp_taken_in;
         rsp_slot_ff    <= rsp_slot_in;
         rsp_label_ff   <= rsp_label_in;
         rsp_char_ff    <= rsp_char_in;
         rsp_full_ff    <= rsp_full_in;
         rsp_none_ff    <= rsp_none_in;
      end
   end

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_char_ff, rsp_label_ff, rsp_slot_ff});
   assign rsp_tuser  = {rsp_none_ff, rsp_full_ff, rsp_taken_ff, rsp_matched_ff};

   // checks
   `WKCM_ASSERT_ALWAYS(a_choice_bound, clock, reset, choices_taken_ff <= COUNT_BITS'(MAX_CHOICES), "choice count past list size")
   `WKCM_ASSERT_NEXT(a_slot_follows_count, clock, reset, advance && take, choices_taken_ff == COUNT_BITS'(rsp_slot_ff + 1'b1), "choice count out of step with slot")
   `WKCM_ASSERT_IMPLY(a_stall_source, clock, reset, !req_tready, a_valid_ff && b_valid_ff && !rsp_tready, "request stalled without a full result stage")
   `WKCM_ASSERT_IMPLY(a_none_vs_match, clock, reset, b_valid_ff && rsp_none_ff, !rsp_matched_ff, "none found on a matching entry")

endmodule
